@@ hdl/src_pkg.sv @@
// Shared types, constants and helper functions for the segment / window clip test.
// No dependencies; every other file in hdl/ except src_out_if refers to this package by scoped names.
package src_pkg;

  // Signed Q16.8 coordinate
  localparam int COORD_W = 24;
  typedef logic signed [COORD_W-1:0] coord_t;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Number of clip passes before an undecided segment is rejected
  localparam int MAX_CLIPS = 4;

  // Divider geometry: quotient bits kept below the overflow threshold
  localparam int DIFF_W  = COORD_W + 1;           // endpoint / edge differences
  localparam int PROD_W  = 2 * DIFF_W;            // signed product
  localparam int MAG_W   = PROD_W - 1;            // product magnitude
  localparam int QBITS   = COORD_W + 2;           // quotients at or above 2^QBITS saturate
  localparam int STEP_BITS = 2;                   // quotient bits per divider stage
  localparam int DIV_STAGES = QBITS / STEP_BITS;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } reg_idx_t;

  // Outcode bits
  localparam int CODE_LEFT   = 0;
  localparam int CODE_RIGHT  = 1;
  localparam int CODE_BOTTOM = 2;
  localparam int CODE_TOP    = 3;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } win_t;

  // Segment as it travels through the clip passes
  typedef struct packed {
    coord_t     x0;
    coord_t     y0;
    coord_t     x1;
    coord_t     y1;
    logic [3:0] c0;
    logic [3:0] c1;
    logic       done;
    logic       hit;
  } seg_t;

  // Per-clip control carried alongside the arithmetic
  typedef struct packed {
    seg_t   seg;
    logic   sel;    // 1: start point moves, 0: end point moves
    logic   side;   // 1: y is interpolated (vertical edge), 0: x is interpolated
    coord_t a0;     // base of the interpolated coordinate
    coord_t fix;    // edge value taken by the other coordinate
    coord_t keep;   // value used on a zero divisor
  } ctl_t;

  // Divider pipeline word
  typedef struct packed {
    ctl_t              ctl;
    logic              neg;
    logic              zdiv;
    logic              ovf;
    logic [DIFF_W-1:0] rem;
    logic [QBITS-1:0]  qn;   // remaining dividend bits shift out, quotient bits shift in
    logic [DIFF_W-1:0] den;
  } div_t;

  function automatic logic [3:0] outcode(coord_t x, coord_t y, win_t w);
    logic [3:0] c;
    c = '0;
    if (x < w.left) begin
      c[CODE_LEFT] = 1'b1;
    end else if (x > w.right) begin
      c[CODE_RIGHT] = 1'b1;
    end
    if (y < w.top) begin
      c[CODE_BOTTOM] = 1'b1;
    end else if (y > w.bottom) begin
      c[CODE_TOP] = 1'b1;
    end
    return c;
  endfunction

  // Trivial accept / reject of a segment that is still open
  function automatic seg_t decide(seg_t s);
    seg_t r;
    r = s;
    if (!s.done) begin
      if ((s.c0 | s.c1) == 4'd0) begin
        r.done = 1'b1;
        r.hit  = 1'b1;
      end else if ((s.c0 & s.c1) != 4'd0) begin
        r.done = 1'b1;
        r.hit  = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/src_in_if.sv @@
// Segment request channel: valid/ready handshake with both endpoints.
// Depends on src_pkg for the coordinate type.
interface src_in_if;
  logic           valid;
  logic           ready;
  src_pkg::coord_t start_x;
  src_pkg::coord_t start_y;
  src_pkg::coord_t end_x;
  src_pkg::coord_t end_y;

  modport source(output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

@@ hdl/src_out_if.sv @@
// Result channel: valid/ready handshake carrying the window hit flag.
// No dependencies.
interface src_out_if;
  logic valid;
  logic ready;
  logic hits_window;

  modport source(output valid, hits_window, input ready);
  modport sink(input valid, hits_window, output ready);
endinterface

@@ hdl/src_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on src_pkg for widths.
interface src_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [src_pkg::CFG_IDX_W-1:0]  index;
  src_pkg::coord_t                data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ hdl/src_div_step.sv @@
// One divider stage: STEP_BITS restoring quotient bits, payload carried along.
// Depends on src_pkg (div_t, widths).
module src_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  src_pkg::div_t  in_d,
  output logic           out_v,
  output src_pkg::div_t  out_d
);

  logic          v_r;
  src_pkg::div_t d_r, d_nxt;

  // Shift in one dividend bit per step, subtract when the divisor fits
  always_comb begin
    logic [src_pkg::DIFF_W:0] r;
    logic                     ge;
    d_nxt = in_d;
    for (int k = 0; k < src_pkg::STEP_BITS; k++) begin
      r  = {d_nxt.rem, d_nxt.qn[src_pkg::QBITS-1]};
      ge = (r >= {1'b0, d_nxt.den});
      if (ge) begin
        r = r - {1'b0, d_nxt.den};
      end
      d_nxt.rem = r[src_pkg::DIFF_W-1:0];
      d_nxt.qn  = {d_nxt.qn[src_pkg::QBITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_v = v_r;
  assign out_d = d_r;

endmodule

@@ hdl/src_clip_unit.sv @@
// One clip pass: decide, pick edge, multiply, divide (pipelined), move endpoint.
// Depends on src_pkg and src_div_step.
module src_clip_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  src_pkg::win_t  win,
  input  logic           in_v,
  input  src_pkg::seg_t  in_seg,
  output logic           out_v,
  output src_pkg::seg_t  out_seg
);

  localparam int DW = src_pkg::DIFF_W;

  // Stage 0: trivial decision, edge choice and operand setup
  logic              s0_v_r;
  src_pkg::ctl_t     s0_ctl_r, s0_ctl_nxt;
  logic signed [DW-1:0] s0_ma_r, s0_ma_nxt, s0_mb_r, s0_mb_nxt, s0_db_r, s0_db_nxt;

  always_comb begin
    src_pkg::seg_t s;
    logic [3:0]    co;
    logic signed [DW-1:0] dx, dy;
    s  = src_pkg::decide(in_seg);
    co = (s.c0 != 4'd0) ? s.c0 : s.c1;
    dx = DW'(s.x1) - DW'(s.x0);
    dy = DW'(s.y1) - DW'(s.y0);
    s0_ctl_nxt.seg = s;
    s0_ctl_nxt.sel = (s.c0 != 4'd0);
    if (co[src_pkg::CODE_TOP] || co[src_pkg::CODE_BOTTOM]) begin
      s0_ctl_nxt.side = 1'b0;
      s0_ctl_nxt.a0   = s.x0;
      s0_ctl_nxt.fix  = co[src_pkg::CODE_TOP] ? win.bottom : win.top;
      s0_ctl_nxt.keep = s0_ctl_nxt.sel ? s.x0 : s.x1;
      s0_ma_nxt       = dx;
      s0_mb_nxt       = DW'(s0_ctl_nxt.fix) - DW'(s.y0);
      s0_db_nxt       = dy;
    end else begin
      s0_ctl_nxt.side = 1'b1;
      s0_ctl_nxt.a0   = s.y0;
      s0_ctl_nxt.fix  = co[src_pkg::CODE_RIGHT] ? win.right : win.left;
      s0_ctl_nxt.keep = s0_ctl_nxt.sel ? s.y0 : s.y1;
      s0_ma_nxt       = dy;
      s0_mb_nxt       = DW'(s0_ctl_nxt.fix) - DW'(s.x0);
      s0_db_nxt       = dx;
    end
  end

  // Stage 1: signed product
  logic              s1_v_r;
  src_pkg::ctl_t     s1_ctl_r;
  logic signed [src_pkg::PROD_W-1:0] s1_p_r, s1_p_nxt;
  logic signed [DW-1:0] s1_db_r;

  assign s1_p_nxt = s0_ma_r * s0_mb_r;

  // Stage 2: magnitudes and quotient sign
  logic              s2_v_r;
  src_pkg::ctl_t     s2_ctl_r;
  logic              s2_neg_r, s2_neg_nxt, s2_zdiv_r, s2_zdiv_nxt;
  logic [src_pkg::MAG_W-1:0] s2_n_r, s2_n_nxt;
  logic [DW-1:0]     s2_d_r, s2_d_nxt;

  always_comb begin
    logic [src_pkg::PROD_W-1:0] pa;
    pa          = s1_p_r[src_pkg::PROD_W-1] ? (-s1_p_r) : s1_p_r;
    s2_n_nxt    = pa[src_pkg::MAG_W-1:0];
    s2_d_nxt    = s1_db_r[DW-1] ? DW'(-s1_db_r) : DW'(s1_db_r);
    s2_neg_nxt  = s1_p_r[src_pkg::PROD_W-1] ^ s1_db_r[DW-1];
    s2_zdiv_nxt = (s1_db_r == '0);
  end

  // Stage 3: overflow test and divider load
  logic              s3_v_r;
  src_pkg::div_t     s3_d_r, s3_d_nxt;

  always_comb begin
    logic [DW-1:0] hi;
    hi             = DW'(s2_n_r[src_pkg::MAG_W-1:src_pkg::QBITS]);
    s3_d_nxt.ctl   = s2_ctl_r;
    s3_d_nxt.neg   = s2_neg_r;
    s3_d_nxt.zdiv  = s2_zdiv_r;
    s3_d_nxt.ovf   = (hi >= s2_d_r);
    s3_d_nxt.rem   = hi;
    s3_d_nxt.qn    = s2_n_r[src_pkg::QBITS-1:0];
    s3_d_nxt.den   = s2_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_v;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctl_r  <= s0_ctl_nxt;
      s0_ma_r   <= s0_ma_nxt;
      s0_mb_r   <= s0_mb_nxt;
      s0_db_r   <= s0_db_nxt;
      s1_ctl_r  <= s0_ctl_r;
      s1_p_r    <= s1_p_nxt;
      s1_db_r   <= s0_db_r;
      s2_ctl_r  <= s1_ctl_r;
      s2_neg_r  <= s2_neg_nxt;
      s2_zdiv_r <= s2_zdiv_nxt;
      s2_n_r    <= s2_n_nxt;
      s2_d_r    <= s2_d_nxt;
      s3_d_r    <= s3_d_nxt;
    end
  end

  // Divider chain
  logic          dv_v [src_pkg::DIV_STAGES+1];
  src_pkg::div_t dv_d [src_pkg::DIV_STAGES+1];

  assign dv_v[0] = s3_v_r;
  assign dv_d[0] = s3_d_r;

  for (genvar g = 0; g < src_pkg::DIV_STAGES; g++) begin : g_div
    src_div_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .in_v  (dv_v[g]),
      .in_d  (dv_d[g]),
      .out_v (dv_v[g+1]),
      .out_d (dv_d[g+1])
    );
  end

  // Stage F1: signed quotient, add base, saturate
  src_pkg::div_t fq;
  logic          f1_v_r;
  src_pkg::ctl_t f1_ctl_r;
  src_pkg::coord_t f1_c_r, f1_c_nxt;

  assign fq = dv_d[src_pkg::DIV_STAGES];

  always_comb begin
    logic signed [src_pkg::QBITS+1:0] sq, sum;
    sq  = fq.neg ? -$signed({2'b00, fq.qn}) : $signed({2'b00, fq.qn});
    sum = (src_pkg::QBITS+2)'(fq.ctl.a0) + sq;
    if (fq.zdiv) begin
      f1_c_nxt = fq.ctl.keep;
    end else if (fq.ovf) begin
      f1_c_nxt = fq.neg ? src_pkg::COORD_MIN : src_pkg::COORD_MAX;
    end else if (sum > (src_pkg::QBITS+2)'(src_pkg::COORD_MAX)) begin
      f1_c_nxt = src_pkg::COORD_MAX;
    end else if (sum < (src_pkg::QBITS+2)'(src_pkg::COORD_MIN)) begin
      f1_c_nxt = src_pkg::COORD_MIN;
    end else begin
      f1_c_nxt = sum[src_pkg::COORD_W-1:0];
    end
  end

  // Stage F2: move the chosen endpoint and refresh its outcode
  logic          f2_v_r;
  src_pkg::seg_t f2_seg_r, f2_seg_nxt;

  always_comb begin
    src_pkg::coord_t nx, ny;
    f2_seg_nxt = f1_ctl_r.seg;
    nx = f1_ctl_r.side ? f1_ctl_r.fix : f1_c_r;
    ny = f1_ctl_r.side ? f1_c_r : f1_ctl_r.fix;
    if (!f1_ctl_r.seg.done) begin
      if (f1_ctl_r.sel) begin
        f2_seg_nxt.x0 = nx;
        f2_seg_nxt.y0 = ny;
        f2_seg_nxt.c0 = src_pkg::outcode(nx, ny, win);
      end else begin
        f2_seg_nxt.x1 = nx;
        f2_seg_nxt.y1 = ny;
        f2_seg_nxt.c1 = src_pkg::outcode(nx, ny, win);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= dv_v[src_pkg::DIV_STAGES];
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ctl_r <= fq.ctl;
      f1_c_r   <= f1_c_nxt;
      f2_seg_r <= f2_seg_nxt;
    end
  end

  assign out_v   = f2_v_r;
  assign out_seg = f2_seg_r;

endmodule

@@ hdl/segment_rect_clip_test_top.sv @@
// Segment / window clip test, top level: config registers, input stage,
// MAX_CLIPS clip passes, final decision and output register.
// Depends on src_pkg, src_in_if, src_out_if, src_cfg_if and src_clip_unit.
//
// Usage:
//   in_seg  : one request per segment (start_x, start_y, end_x, end_y, Q16.8).
//   out_res : one hits_window flag per request, in request order.
//   cfg_wr  : index 0..3 writes left, top, right, bottom; always ready.
//             Write only while no request is in flight.
// Throughput: one request per cycle while not stalled. Every clip pass is fully pipelined:
//   edge setup, 25x25 multiply, magnitude, overflow test, a 13-stage
//   two-bit-per-stage divider and two stages to move the endpoint.
// Reset: clears all valid bits and the window registers to 0.
// Stall: while a result waits on out_res the whole pipeline holds and
//   in_seg.ready is low; nothing is dropped or repeated.
module segment_rect_clip_test_top (
  input  logic       clk,
  input  logic       rst_n,
  src_in_if.sink     in_seg,
  src_out_if.source  out_res,
  src_cfg_if.sink    cfg_wr
);

  localparam int NC = src_pkg::MAX_CLIPS;

  logic en;

  // Window registers
  src_pkg::win_t win_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (cfg_wr.valid) begin
      case (src_pkg::reg_idx_t'(cfg_wr.index))
        src_pkg::REG_LEFT:   win_r.left   <= cfg_wr.data;
        src_pkg::REG_TOP:    win_r.top    <= cfg_wr.data;
        src_pkg::REG_RIGHT:  win_r.right  <= cfg_wr.data;
        src_pkg::REG_BOTTOM: win_r.bottom <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // Global advance: the output register is free or being drained
  logic          out_v_r;
  logic          hit_r, hit_nxt;

  assign en           = !out_v_r || out_res.ready;
  assign in_seg.ready = en;

  // Input stage: capture endpoints and form outcodes
  logic          in_v_r;
  src_pkg::seg_t in_seg_r, in_seg_nxt;

  always_comb begin
    in_seg_nxt.x0   = in_seg.start_x;
    in_seg_nxt.y0   = in_seg.start_y;
    in_seg_nxt.x1   = in_seg.end_x;
    in_seg_nxt.y1   = in_seg.end_y;
    in_seg_nxt.c0   = src_pkg::outcode(in_seg.start_x, in_seg.start_y, win_r);
    in_seg_nxt.c1   = src_pkg::outcode(in_seg.end_x, in_seg.end_y, win_r);
    in_seg_nxt.done = 1'b0;
    in_seg_nxt.hit  = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (en) begin
      in_v_r <= in_seg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_seg_r <= in_seg_nxt;
    end
  end

  // Clip passes
  logic          cv [NC+1];
  src_pkg::seg_t cs [NC+1];

  assign cv[0] = in_v_r;
  assign cs[0] = in_seg_r;

  for (genvar g = 0; g < NC; g++) begin : g_clip
    src_clip_unit u_clip (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .win     (win_r),
      .in_v    (cv[g]),
      .in_seg  (cs[g]),
      .out_v   (cv[g+1]),
      .out_seg (cs[g+1])
    );
  end

  // Final decision: still open after the last pass means rejected
  src_pkg::seg_t last_seg;

  assign last_seg = src_pkg::decide(cs[NC]);
  assign hit_nxt  = last_seg.done && last_seg.hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= cv[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= hit_nxt;
    end
  end

  assign out_res.valid       = out_v_r;
  assign out_res.hits_window = hit_r;

  // Output register follows the last pass whenever the pipeline advances
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (out_v_r == $past(cv[NC])))
    else $error("output valid does not follow last clip pass");

  // A pending result stalls the input side
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_res.ready) |-> !in_seg.ready)
    else $error("input accepted while result is stalled");

  // A segment marked hit has been decided
  a_hit_decided: assert property (@(posedge clk) disable iff (!rst_n)
    (cv[NC] && cs[NC].hit) |-> cs[NC].done)
    else $error("hit flag set on an undecided segment");

endmodule
